### src/hcbp_pkg.sv
// Package for the Huffman code bit packer: shared constants, input mode codes
// and the push command that passes from the front end to the queue.
// No dependencies.
package hcbp_pkg;

   // Default sizes for the top-level parameters.
   localparam int DEF_SYMBOL_COUNT = 256;
   localparam int DEF_MAX_CODE_LEN = 32;

   // Width of one output word and of the fill counter.
   localparam int BYTE_BITS = 8;
   localparam int FILL_W    = 3;

   // Depth of the command queue between the front end and the packer.
   localparam int QUEUE_DEPTH = 4;

   // Input mode codes.
   localparam logic [1:0] MODE_LOAD   = 2'd0;
   localparam logic [1:0] MODE_ENCODE = 2'd1;
   localparam logic [1:0] MODE_FLUSH  = 2'd2;

   // Push control from the front end to the command queue.
   typedef struct packed {
      logic valid;
      logic flush;
   } cmd_type;

endpackage

### src/hcbp_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
module hcbp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### src/hcbp_front.sv
// Front end of the code bit packer: accepts input words, writes code table
// entries and issues table reads for encode and flush commands. Uses hcbp_pkg.
module hcbp_front #(
   parameter int SYMBOL_COUNT = 256,
   parameter int MAX_CODE_LEN = 32,
   parameter int ADDR_W       = 8,
   parameter int LEN_W        = 6,
   parameter int COUNT_W      = 3
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [1:0]             req_mode,
   input  logic [7:0]             req_symbol,
   input  logic [31:0]            req_code_value,
   input  logic [5:0]             req_code_len,
   input  logic [COUNT_W-1:0]     q_count,
   output logic                   tab_wr_en,
   output logic [ADDR_W-1:0]      tab_addr,
   output logic [MAX_CODE_LEN+LEN_W-1:0] tab_wr_data,
   output hcbp_pkg::cmd_type      push_cmd
);
   import hcbp_pkg::*;

   logic                    accept;
   logic                    in_range;
   logic [5:0]              len_sat;
   logic [MAX_CODE_LEN-1:0] code_masked;
   logic                    issue;
   logic                    pend_ff, pend_in;
   logic                    pend_flush_ff, pend_flush_in;

   // Hold off input while the queue could not take the word in flight.
   assign req_stall = (q_count + COUNT_W'(pend_ff)) >= COUNT_W'(QUEUE_DEPTH);
   assign accept    = req_valid && !req_stall;
   assign in_range  = {1'b0, req_symbol} < 9'(SYMBOL_COUNT);

   // Saturate the length and clear code bits above it.
   always_comb begin
      len_sat = (req_code_len > 6'(MAX_CODE_LEN)) ? 6'(MAX_CODE_LEN)
                                                  : req_code_len;
      for (int i = 0; i < MAX_CODE_LEN; i++) begin
         code_masked[i] = req_code_value[i] && (6'(i) < len_sat);
      end
   end

   // Table write for loads; reads for encodes share the same address.
   assign tab_wr_en   = accept && (req_mode == MODE_LOAD) && in_range;
   assign tab_addr    = req_symbol[ADDR_W-1:0];
   assign tab_wr_data = {code_masked, len_sat[LEN_W-1:0]};

   // Encode and flush words wait in the pending register for the registered table read data.
   assign issue = accept && (((req_mode == MODE_ENCODE) && in_range) ||
                             (req_mode == MODE_FLUSH));
   assign pend_in       = issue;
   assign pend_flush_in = (req_mode == MODE_FLUSH);

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= pend_in;
      end
      pend_flush_ff <= pend_flush_in;
   end

   assign push_cmd.valid = pend_ff;
   assign push_cmd.flush = pend_flush_ff;

endmodule

### src/hcbp_queue.sv
// Short command queue between the front end and the packer back end.
// Uses hcbp_pkg for the push command and the queue depth.
module hcbp_queue #(
   parameter int MAX_CODE_LEN = 32,
   parameter int LEN_W        = 6,
   parameter int COUNT_W      = 3
) (
   input  logic                    clock,
   input  logic                    reset,
   input  hcbp_pkg::cmd_type       push_cmd,
   input  logic [MAX_CODE_LEN+LEN_W-1:0] push_data,
   input  logic                    pop,
   output logic                    empty,
   output logic [COUNT_W-1:0]      count,
   output logic                    head_flush,
   output logic [MAX_CODE_LEN-1:0] head_code,
   output logic [LEN_W-1:0]        head_len
);
   import hcbp_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   logic                    flush_ff [QUEUE_DEPTH];
   logic [MAX_CODE_LEN-1:0] code_ff  [QUEUE_DEPTH];
   logic [LEN_W-1:0]        len_ff   [QUEUE_DEPTH];
   logic [PTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0]      count_ff, count_in;

   // Pointer and occupancy updates.
   always_comb begin
      wr_ptr_in = push_cmd.valid ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + COUNT_W'(push_cmd.valid) - COUNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push_cmd.valid) begin
         flush_ff[wr_ptr_ff] <= push_cmd.flush;
         code_ff[wr_ptr_ff]  <= push_data[MAX_CODE_LEN+LEN_W-1:LEN_W];
         len_ff[wr_ptr_ff]   <= push_data[LEN_W-1:0];
      end
   end

   assign empty      = (count_ff == '0);
   assign count      = count_ff;
   assign head_flush = flush_ff[rd_ptr_ff];
   assign head_code  = code_ff[rd_ptr_ff];
   assign head_len   = len_ff[rd_ptr_ff];

endmodule

### src/hcbp_back.sv
// Packer back end: appends code bits to the byte accumulator, most
// significant bit first, and sends one byte a cycle when not stalled. Uses hcbp_pkg.
module hcbp_back #(
   parameter int MAX_CODE_LEN = 32,
   parameter int LEN_W        = 6
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_empty,
   input  logic                    head_flush,
   input  logic [MAX_CODE_LEN-1:0] head_code,
   input  logic [LEN_W-1:0]        head_len,
   output logic                    pop,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [7:0]              rsp_out_byte,
   output logic                    rsp_last
);
   import hcbp_pkg::*;

   localparam int WIN_W = MAX_CODE_LEN + BYTE_BITS;
   localparam int CNT_W = $clog2(WIN_W);
   localparam int SH_W  = $clog2(WIN_W + 1);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EMIT = 1'b1;

   logic                   state_ff, state_in;
   logic [BYTE_BITS-1:0]   acc_ff, acc_in;
   logic [FILL_W-1:0]      fill_ff, fill_in;
   logic [WIN_W-1:0]       win_ff, win_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [BYTE_BITS-1:0]   rsp_byte_ff, rsp_byte_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic                   out_free;
   logic [SH_W-1:0]        shamt;
   logic [WIN_W-1:0]       win_new;
   logic [CNT_W-1:0]       total;
   logic [CNT_W-1:0]       cnt_rem;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Left-aligned window: pending bits on top, the new code right below them.
   always_comb begin
      shamt   = SH_W'(WIN_W) - SH_W'(head_len) - SH_W'(fill_ff);
      win_new = {acc_ff, {MAX_CODE_LEN{1'b0}}} | (WIN_W'(head_code) << shamt);
      total   = CNT_W'(fill_ff) + CNT_W'(head_len);
      cnt_rem = cnt_ff - CNT_W'(BYTE_BITS);
   end

   // Sequencer: take a command, then send its bytes one per cycle unless stalled.
   always_comb begin
      state_in     = state_ff;
      acc_in       = acc_ff;
      fill_in      = fill_ff;
      win_in       = win_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      pop          = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (!q_empty && out_free) begin
               pop = 1'b1;
               if (head_flush) begin
                  if (fill_ff != '0) begin
                     rsp_valid_in = 1'b1;
                     rsp_byte_in  = acc_ff;
                     rsp_last_in  = 1'b1;
                     acc_in       = '0;
                     fill_in      = '0;
                  end
               end else if (total >= CNT_W'(BYTE_BITS)) begin
                  win_in   = win_new;
                  cnt_in   = total;
                  state_in = ST_EMIT;
               end else begin
                  acc_in  = win_new[WIN_W-1 -: BYTE_BITS];
                  fill_in = total[FILL_W-1:0];
               end
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = win_ff[WIN_W-1 -: BYTE_BITS];
               rsp_last_in  = (cnt_rem < CNT_W'(BYTE_BITS));
               win_in       = win_ff << BYTE_BITS;
               cnt_in       = cnt_rem;
               if (cnt_rem < CNT_W'(BYTE_BITS)) begin
                  acc_in   = win_ff[WIN_W-BYTE_BITS-1 -: BYTE_BITS];
                  fill_in  = cnt_rem[FILL_W-1:0];
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         acc_ff       <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      win_ff      <= win_in;
      cnt_ff      <= cnt_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_last     = rsp_last_ff;

endmodule

### src/huffman_code_bit_packer.sv
// Huffman code bit packer, top level: front end, code table RAM, command
// queue and packer back end. Uses hcbp_pkg and all hcbp_* modules.
//
// A load word writes one code table entry. An encode word reads its code
// from the table, and the packer then takes the command and sends each
// output byte it completes; a flush sends any partial byte. The packer has
// a single output byte register. Encode and flush words pass through the
// registered table read before they enter a four-word queue, so the input
// side keeps accepting while the packer is busy, until the queue is full.
// Every output word's last flag marks the final byte caused by one input
// word. Entries must be loaded before they are encoded.
module huffman_code_bit_packer #(
   parameter int SYMBOL_COUNT = hcbp_pkg::DEF_SYMBOL_COUNT,
   parameter int MAX_CODE_LEN = hcbp_pkg::DEF_MAX_CODE_LEN
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic [7:0]  req_symbol,
   input  logic [31:0] req_code_value,
   input  logic [5:0]  req_code_len,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_last
);
   import hcbp_pkg::*;

   localparam int ADDR_W  = $clog2(SYMBOL_COUNT);
   localparam int LEN_W   = $clog2(MAX_CODE_LEN + 1);
   localparam int ENTRY_W = MAX_CODE_LEN + LEN_W;
   localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

   logic                    tab_wr_en;
   logic [ADDR_W-1:0]       tab_addr;
   logic [ENTRY_W-1:0]      tab_wr_data;
   logic [ENTRY_W-1:0]      tab_rd_data;
   cmd_type                 push_cmd;
   logic                    pop;
   logic                    q_empty;
   logic [COUNT_W-1:0]      q_count;
   logic                    head_flush;
   logic [MAX_CODE_LEN-1:0] head_code;
   logic [LEN_W-1:0]        head_len;

   // Input word handling and table writes.
   hcbp_front #(
      .SYMBOL_COUNT (SYMBOL_COUNT),
      .MAX_CODE_LEN (MAX_CODE_LEN),
      .ADDR_W       (ADDR_W),
      .LEN_W        (LEN_W),
      .COUNT_W      (COUNT_W)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_mode       (req_mode),
      .req_symbol     (req_symbol),
      .req_code_value (req_code_value),
      .req_code_len   (req_code_len),
      .q_count        (q_count),
      .tab_wr_en      (tab_wr_en),
      .tab_addr       (tab_addr),
      .tab_wr_data    (tab_wr_data),
      .push_cmd       (push_cmd)
   );

   // Code table: code bits above, length below.
   hcbp_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SYMBOL_COUNT)
   ) u_table (
      .clock   (clock),
      .wr_en   (tab_wr_en),
      .wr_addr (tab_addr),
      .wr_data (tab_wr_data),
      .rd_addr (tab_addr),
      .rd_data (tab_rd_data)
   );

   // Command queue between the two halves.
   hcbp_queue #(
      .MAX_CODE_LEN (MAX_CODE_LEN),
      .LEN_W        (LEN_W),
      .COUNT_W      (COUNT_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_cmd   (push_cmd),
      .push_data  (tab_rd_data),
      .pop        (pop),
      .empty      (q_empty),
      .count      (q_count),
      .head_flush (head_flush),
      .head_code  (head_code),
      .head_len   (head_len)
   );

   // Bit packer and output word register.
   hcbp_back #(
      .MAX_CODE_LEN (MAX_CODE_LEN),
      .LEN_W        (LEN_W)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .q_empty      (q_empty),
      .head_flush   (head_flush),
      .head_code    (head_code),
      .head_len     (head_len),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last)
   );

endmodule
